// ----- design/fnlf_pkg.sv -----
// Shared constants, types and helper functions for the fast natural log core.
// Used by the core, split, multiply-add and delay modules; depends on nothing else.
package fnlf_pkg;

  // Register stages in one fused multiply-add unit.
  localparam int FMA_LAT = 5;
  // Signed width for internal exponents; ample for every finite operand.
  localparam int EXP_W = 13;

  typedef logic signed [EXP_W-1:0] exp_t;

  localparam logic [31:0] SPLIT_K    = 32'h3f2aaaab;
  localparam logic [31:0] SPLIT_MASK = 32'hff800000;
  localparam logic [31:0] F_ONE      = 32'h3f800000;
  localparam logic [31:0] F_NEG_ONE  = 32'hbf800000;
  localparam logic [31:0] F_NEG_ZERO = 32'h80000000;
  localparam logic [31:0] F_INF_EXP  = 32'h7f800000;
  localparam logic [31:0] F_C4       = 32'h3e6c6078;
  localparam logic [31:0] F_C3       = 32'hbe8ef46d;
  localparam logic [31:0] F_C2       = 32'h3ea9e51a;
  localparam logic [31:0] F_C1       = 32'hbeff712d;
  localparam logic [31:0] F_LN2      = 32'h3f317218;

  // Index of the highest set bit; zero for a zero word.
  function automatic logic [5:0] top_bit64(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) p = 6'(k);
    end
    return p;
  endfunction

  // Exponent of the integer significand of a finite float.
  function automatic exp_t unpack_exp(input logic [7:0] be);
    exp_t r;
    if (be == 8'd0) r = exp_t'(-149);
    else r = exp_t'({5'b0, be}) - exp_t'(150);
    return r;
  endfunction

endpackage

// ----- design/fast_natural_log_float_core.sv -----
// Fast single-precision natural log: one request accepted per clock while the
// output does not stall; each passes one split stage and then five chained
// five-stage multiply-add levels. A stall on the output freezes the whole pipeline.
// Depends on fnlf_pkg, fnlf_split, fnlf_fma and fnlf_dly.
module fast_natural_log_float_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_log_bits
);
  import fnlf_pkg::*;

  logic        adv;
  logic        v0, v1, v2, v3, v4;
  logic [31:0] mant, expo, f, s, r1, t, r2, r3;
  logic [31:0] expo_d1, expo_d2, expo_d3, expo_d4;
  logic [31:0] f_d1, f_d2, s_d1;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  fnlf_split u_split (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(in_valid),
    .operand(in_operand_bits), .out_valid(v0), .mant(mant), .expo(expo)
  );

  fnlf_fma u_f (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v0),
    .a(mant), .b(F_ONE), .c(F_NEG_ONE), .out_valid(v1), .y(f)
  );

  fnlf_fma u_s (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v1),
    .a(f), .b(f), .c(F_NEG_ZERO), .out_valid(), .y(s)
  );

  fnlf_fma u_r1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v1),
    .a(F_C4), .b(f), .c(F_C3), .out_valid(v2), .y(r1)
  );

  fnlf_fma u_t (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v1),
    .a(F_C2), .b(f), .c(F_C1), .out_valid(), .y(t)
  );

  fnlf_fma u_r2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v2),
    .a(r1), .b(s), .c(t), .out_valid(v3), .y(r2)
  );

  fnlf_dly u_sd1 (.clk(clk), .en(adv), .d(s), .q(s_d1));
  fnlf_dly u_fd1 (.clk(clk), .en(adv), .d(f), .q(f_d1));
  fnlf_dly u_fd2 (.clk(clk), .en(adv), .d(f_d1), .q(f_d2));

  fnlf_fma u_r3 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v3),
    .a(r2), .b(s_d1), .c(f_d2), .out_valid(v4), .y(r3)
  );

  fnlf_dly u_ed1 (.clk(clk), .en(adv), .d(expo), .q(expo_d1));
  fnlf_dly u_ed2 (.clk(clk), .en(adv), .d(expo_d1), .q(expo_d2));
  fnlf_dly u_ed3 (.clk(clk), .en(adv), .d(expo_d2), .q(expo_d3));
  fnlf_dly u_ed4 (.clk(clk), .en(adv), .d(expo_d3), .q(expo_d4));

  fnlf_fma u_out (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v4),
    .a(expo_d4), .b(F_LN2), .c(r3), .out_valid(out_valid), .y(out_log_bits)
  );
endmodule

// ----- design/fnlf_split.sv -----
// Front stage: splits the operand into a mantissa in [2/3, 4/3) and the
// exponent term as an exact float. Depends on fnlf_pkg.
module fnlf_split (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] operand,
  output logic        out_valid,
  output logic [31:0] mant,
  output logic [31:0] expo
);
  import fnlf_pkg::*;

  logic [31:0] e_word;
  logic [8:0]  n;
  logic        neg;
  logic [8:0]  mag;
  logic [5:0]  p;
  logic [31:0] sft;
  logic [31:0] expo_nxt;
  logic [31:0] mant_r, expo_r;
  logic        valid_r;

  always_comb begin
    e_word = (operand - SPLIT_K) & SPLIT_MASK;
    n      = e_word[31:23];
    neg    = n[8];
    mag    = neg ? (9'd0 - n) : n;
    p      = top_bit64({55'b0, mag});
    sft    = {23'b0, mag} << (6'd23 - p);
    // The exponent term is a small integer, so its float form is exact.
    if (n == 9'd0) expo_nxt = '0;
    else expo_nxt = {neg, 8'd127 + {2'b0, p}, sft[22:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant_r <= operand - e_word;
      expo_r <= expo_nxt;
    end
  end

  assign out_valid = valid_r;
  assign mant      = mant_r;
  assign expo      = expo_r;
endmodule

// ----- design/fnlf_fma.sv -----
// Five-stage fused multiply-add a*b + c with one round to nearest even.
// Operands are always finite here. Depends on fnlf_pkg.
module fnlf_fma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        out_valid,
  output logic [31:0] y
);
  import fnlf_pkg::*;

  // Stage 1: significand product.
  logic [23:0] sig_a, sig_b, sig_c;
  logic [47:0] s1_prod_r;
  exp_t        s1_ex_r, s1_ec_r;
  logic [23:0] s1_sigc_r;
  logic [31:0] s1_c_r;
  logic        s1_sp_r, s1_sc_r, s1_pz_r, s1_zc_r, s1_v_r;

  always_comb begin
    sig_a = {(a[30:23] != 8'd0), a[22:0]};
    sig_b = {(b[30:23] != 8'd0), b[22:0]};
    sig_c = {(c[30:23] != 8'd0), c[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r <= sig_a * sig_b;
      s1_ex_r   <= unpack_exp(a[30:23]) + unpack_exp(b[30:23]);
      s1_ec_r   <= unpack_exp(c[30:23]);
      s1_sigc_r <= sig_c;
      s1_c_r    <= c;
      s1_sp_r   <= a[31] ^ b[31];
      s1_sc_r   <= c[31];
      s1_pz_r   <= (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
      s1_zc_r   <= (c[30:0] == 31'd0);
    end
  end

  // Stage 2: normalize both terms so the top bit sits at bit 61.
  logic [5:0]  px, py, shx, shy;
  logic [63:0] xn, yn;
  logic [31:0] spec_val;
  logic [63:0] s2_x_r, s2_y_r;
  exp_t        s2_ex_r, s2_ey_r;
  logic        s2_sp_r, s2_sc_r, s2_zc_r, s2_spec_r, s2_v_r;
  logic [31:0] s2_sval_r;

  always_comb begin
    px  = top_bit64({16'b0, s1_prod_r});
    py  = top_bit64({40'b0, s1_sigc_r});
    shx = 6'd61 - px;
    shy = 6'd61 - py;
    xn  = {16'b0, s1_prod_r} << shx;
    yn  = {40'b0, s1_sigc_r} << shy;
    // A zero product passes the addend through, with the signed zero rule.
    if (s1_zc_r) spec_val = (s1_sp_r && s1_sc_r) ? F_NEG_ZERO : 32'd0;
    else spec_val = s1_c_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r    <= xn;
      s2_y_r    <= yn;
      s2_ex_r   <= s1_ex_r - exp_t'({7'b0, shx});
      s2_ey_r   <= s1_ec_r - exp_t'({7'b0, shy});
      s2_sp_r   <= s1_sp_r;
      s2_sc_r   <= s1_sc_r;
      s2_zc_r   <= s1_zc_r;
      s2_spec_r <= s1_pz_r;
      s2_sval_r <= spec_val;
    end
  end

  // Stage 3: align the smaller term with a sticky bit, then add or subtract.
  logic        swap;
  logic [63:0] big, lesser, al, mask, sum;
  exp_t        eb, es, d;
  logic        sb, ss, sgn;
  logic [63:0] s3_sum_r;
  exp_t        s3_ex_r;
  logic        s3_sign_r, s3_spec_r, s3_v_r;
  logic [31:0] s3_sval_r;

  always_comb begin
    swap   = !s2_zc_r && (s2_ey_r > s2_ex_r);
    big    = swap ? s2_y_r : s2_x_r;
    lesser = swap ? s2_x_r : s2_y_r;
    eb     = swap ? s2_ey_r : s2_ex_r;
    es     = swap ? s2_ex_r : s2_ey_r;
    sb     = swap ? s2_sc_r : s2_sp_r;
    ss     = swap ? s2_sp_r : s2_sc_r;
    d      = eb - es;
    mask   = (64'd1 << d[5:0]) - 64'd1;
    if (s2_zc_r) al = '0;
    else if (d >= exp_t'(63)) al = 64'd1;
    else if (d > exp_t'(0)) al = (lesser >> d[5:0]) | {63'b0, |(lesser & mask)};
    else al = lesser;
    if (sb == ss) begin
      sum = big + al;
      sgn = sb;
    end else if (big >= al) begin
      sum = big - al;
      sgn = sb;
    end else begin
      sum = al - big;
      sgn = ss;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r  <= sum;
      s3_ex_r   <= eb;
      s3_sign_r <= sgn;
      s3_spec_r <= s2_spec_r;
      s3_sval_r <= s2_sval_r;
    end
  end

  // Stage 4: find the rounding position, clamped at the subnormal limit.
  logic [5:0]  ps;
  exp_t        sh, lo;
  logic [63:0] s4_sum_r;
  exp_t        s4_ex_r, s4_sh_r;
  logic        s4_sign_r, s4_zero_r, s4_spec_r, s4_v_r;
  logic [31:0] s4_sval_r;

  always_comb begin
    ps = top_bit64(s3_sum_r);
    lo = exp_t'(-149) - s3_ex_r;
    sh = exp_t'({7'b0, ps}) - exp_t'(23);
    if (lo > sh) sh = lo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum_r  <= s3_sum_r;
      s4_ex_r   <= s3_ex_r;
      s4_sh_r   <= sh;
      s4_sign_r <= s3_sign_r;
      s4_zero_r <= (s3_sum_r == 64'd0);
      s4_spec_r <= s3_spec_r;
      s4_sval_r <= s3_sval_r;
    end
  end

  // Stage 5: shift, round to nearest even and pack.
  exp_t        nsh, k, be;
  logic [63:0] lsh, rsh, rmask, rem, half;
  logic [24:0] q;
  logic        gone;
  logic [31:0] packed_val, res;
  logic [31:0] s5_y_r;
  logic        s5_v_r;

  always_comb begin
    nsh   = exp_t'(0) - s4_sh_r;
    lsh   = s4_sum_r << nsh[4:0];
    rsh   = s4_sum_r >> s4_sh_r[5:0];
    rmask = (64'd1 << s4_sh_r[5:0]) - 64'd1;
    rem   = s4_sum_r & rmask;
    half  = 64'd1 << (s4_sh_r[5:0] - 6'd1);
    gone  = 1'b0;
    k     = s4_ex_r + s4_sh_r;
    if (s4_sh_r <= exp_t'(0)) begin
      q = lsh[24:0];
    end else if (s4_sh_r >= exp_t'(64)) begin
      q    = '0;
      gone = 1'b1;
    end else begin
      q = rsh[24:0];
      if (rem > half || (rem == half && rsh[0])) q = q + 25'd1;
    end
    if (q[24]) begin
      q = q >> 1;
      k = k + exp_t'(1);
    end
    be = k + exp_t'(150);
    if (gone) packed_val = {s4_sign_r, 31'd0};
    else if (q[23] && be >= exp_t'(255)) packed_val = {s4_sign_r, F_INF_EXP[30:0]};
    else if (q[23]) packed_val = {s4_sign_r, be[7:0], q[22:0]};
    else packed_val = {s4_sign_r, 8'd0, q[22:0]};
    // An exactly cancelling sum is positive zero.
    if (s4_spec_r) res = s4_sval_r;
    else if (s4_zero_r) res = '0;
    else res = packed_val;
  end

  always_ff @(posedge clk) begin
    if (en) s5_y_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  assign out_valid = s5_v_r;
  assign y         = s5_y_r;
endmodule

// ----- design/fnlf_dly.sv -----
// Delay line that matches the latency of one multiply-add unit.
// Depends on fnlf_pkg for that latency.
module fnlf_dly (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] d,
  output logic [31:0] q
);
  import fnlf_pkg::*;

  logic [31:0] tap_r [FMA_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int k = 1; k < FMA_LAT; k++) tap_r[k] <= tap_r[k-1];
    end
  end

  assign q = tap_r[FMA_LAT-1];
endmodule

// ----- design/fnlf_chk.sv -----
// Port-level checker for the fast natural log core, bound to the top level.
// Depends only on the top level's ports.
module fnlf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_log_bits
);

  // The whole pipeline moves as one, so the input stalls exactly when the
  // output holds a result that is not taken.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_log_bits))
    else $error("stalled result changed");

  // With no stall, a cycle without results leaves the input free.
  a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

endmodule

bind fast_natural_log_float_core fnlf_chk u_fnlf_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_log_bits(out_log_bits)
);
